>>> sv/uds_pkg.sv
// shared types and constants for the ungapped diagonal scorer
// no dependencies; imported by every module of the block

package uds_pkg;

    // store geometry
    localparam int MAX_QUERY_LEN = 1024;
    localparam int PROFILE_WIDTH = 32;
    localparam int MAX_DB_LEN    = 65535;
    localparam int QPOS_W        = $clog2(MAX_QUERY_LEN);
    localparam int RES_W         = $clog2(PROFILE_WIDTH);
    localparam int PROF_AW       = QPOS_W + RES_W;
    localparam int PROF_DEPTH    = MAX_QUERY_LEN * PROFILE_WIDTH;

    // field widths
    localparam int LEN_W      = 16;
    localparam int SCORE_W    = 8;
    localparam int QLEN_W     = 11;
    localparam int BIAS_W     = 7;
    localparam int CFG_W      = 11;
    localparam int TDATA_IN_W = 40;
    localparam int TDATA_OUT_W = 32;

    // log2 pipeline
    localparam int LOG_STAGES = 8;
    localparam int K_W        = 4;
    localparam int MANT_W     = 31;

    // register indexes
    localparam logic CFG_QUERY_LENGTH = 1'b0;
    localparam logic CFG_SCORE_BIAS   = 1'b1;

    // item kinds
    localparam logic KIND_PROFILE = 1'b0;
    localparam logic KIND_RESIDUE = 1'b1;

    // residue item waiting on its profile reads
    typedef struct packed {
        logic             fwd_en;
        logic             rev_en;
        logic             col_ok;
        logic             last;
        logic [LEN_W-1:0] len;
    } t_s1_info;

    // finished sequence handed to the normalising pipe
    typedef struct packed {
        logic [SCORE_W-1:0] fwd_best;
        logic [SCORE_W-1:0] rev_best;
        logic [LEN_W-1:0]   len;
    } t_seq_result;

    // one stage of the log2 squaring pipe
    typedef struct packed {
        logic [SCORE_W-1:0] raw;
        logic [K_W-1:0]     k;
        logic [7:0]         frac;
        logic [MANT_W-1:0]  m;
        logic [LEN_W-1:0]   len;
    } t_log_stage;

endpackage

>>> sv/uds_profile_ram.sv
// query profile store: one write port, two registered read ports
// depends on uds_pkg for the store geometry

module uds_profile_ram
    import uds_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [PROF_AW-1:0] i_waddr,
    input  logic [7:0]         i_wdata,
    input  logic               i_re,
    input  logic [PROF_AW-1:0] i_raddr_a,
    input  logic [PROF_AW-1:0] i_raddr_b,
    output logic [7:0]         o_rdata_a,
    output logic [7:0]         o_rdata_b
);

    logic [7:0] mem [PROF_DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, data held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

>>> sv/uds_log2_norm.sv
// log2 in q.8 by repeated squaring, then score normalisation and output register
// depends on uds_pkg for t_seq_result and t_log_stage

module uds_log2_norm
    import uds_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_res_valid,
    output logic                   o_res_ready,
    input  t_seq_result            i_res,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [TDATA_OUT_W-1:0] o_m_tdata
);

    t_log_stage             r_st  [LOG_STAGES+1];
    t_log_stage             n_st  [LOG_STAGES+1];
    logic [LOG_STAGES:0]    r_stv;
    logic [LOG_STAGES:0]    st_rdy;
    logic                   out_rdy;
    logic                   r_ov;
    logic [SCORE_W-1:0]     r_norm;
    logic [SCORE_W-1:0]     r_raw;
    logic [LEN_W-1:0]       r_len;
    logic [2*MANT_W-1:0]    sq    [LOG_STAGES+1];
    logic [MANT_W:0]        sh    [LOG_STAGES+1];
    logic [LEN_W-1:0]       len_eff;
    logic [K_W-1:0]         k0;
    logic signed [LEN_W:0]  diff;

    // ready chain, a stage loads when empty or when it empties this cycle
    always_comb begin
        out_rdy = !r_ov || i_m_tready;
        st_rdy[LOG_STAGES] = !r_stv[LOG_STAGES] || out_rdy;
        for (int i = LOG_STAGES - 1; i >= 0; i--) begin
            st_rdy[i] = !r_stv[i] || st_rdy[i+1];
        end
    end

    assign o_res_ready = st_rdy[0];

    // entry stage: best of both offsets, top bit and normalised mantissa
    always_comb begin
        len_eff = (i_res.len == '0) ? LEN_W'(1) : i_res.len;
        k0 = '0;
        for (int b = 0; b < LEN_W; b++) begin
            if (len_eff[b]) begin
                k0 = K_W'(b);
            end
        end
        n_st[0].raw  = (i_res.fwd_best > i_res.rev_best) ? i_res.fwd_best : i_res.rev_best;
        n_st[0].k    = k0;
        n_st[0].frac = '0;
        n_st[0].m    = MANT_W'(len_eff) << (5'(MANT_W - 1) - {1'b0, k0});
        n_st[0].len  = i_res.len;
        sq[0] = '0;
        sh[0] = '0;
        // one squaring per stage, one fraction bit each
        for (int i = 1; i <= LOG_STAGES; i++) begin
            sq[i] = r_st[i-1].m * r_st[i-1].m;
            sh[i] = sq[i][2*MANT_W-1:MANT_W-1];
            n_st[i]      = r_st[i-1];
            n_st[i].frac = {r_st[i-1].frac[6:0], sh[i][MANT_W]};
            n_st[i].m    = sh[i][MANT_W] ? sh[i][MANT_W:1] : sh[i][MANT_W-1:0];
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stv <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (st_rdy[0]) begin
                r_stv[0] <= i_res_valid;
            end
            for (int i = 1; i <= LOG_STAGES; i++) begin
                if (st_rdy[i]) begin
                    r_stv[i] <= r_stv[i-1];
                end
            end
            if (out_rdy) begin
                r_ov <= r_stv[LOG_STAGES];
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        for (int i = 0; i <= LOG_STAGES; i++) begin
            if (st_rdy[i]) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    // raw * 256 minus q.8 log2, floored at zero
    assign diff = $signed({1'b0, r_st[LOG_STAGES].raw, 8'b0})
                - $signed({5'b0, r_st[LOG_STAGES].k, r_st[LOG_STAGES].frac});

    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_norm <= diff[LEN_W] ? '0 : diff[LEN_W-1:8];
            r_raw  <= r_st[LOG_STAGES].raw;
            r_len  <= r_st[LOG_STAGES].len;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_len, r_raw, r_norm};

    // normalised score never exceeds the raw score
    a_norm_le_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_norm <= r_raw))
        else $error("normalised score above raw score");

    // a blocked entry stage keeps its item
    a_entry_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stv[0] && !st_rdy[1]) |=> (r_stv[0] && $stable(r_st[0])))
        else $error("entry stage item lost while blocked");

endmodule

>>> sv/ungapped_diagonal_score.sv
// top level of the ungapped diagonal scorer: item intake, profile reads and running scores
// depends on uds_pkg, uds_profile_ram and uds_log2_norm
//
// channel   dir  width  contents
// s stream  in   40+2   tdata: query_pos, residue, profile_value, diagonal; tuser kind; tlast
// m stream  out  32     tdata: normalized_score, raw_score, sequence_length
// cfg       in   1+11   register index and write data, write on i_cfg_we
//
// one item per cycle while no last residue is held in the update stage
// a profile write lands in the store at its accept edge; after its last residue, a result passes
// the score update into the log2 entry stage, eight squaring stages and the output register
// reset is synchronous; the profile store is not cleared and needs no sweep
// output stalls back up through the ten pipe registers before intake stops

module ungapped_diagonal_score
    import uds_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [TDATA_IN_W-1:0]  i_s_tdata,   // query_pos, residue, profile_value, diagonal, pad
    input  logic                   i_s_tuser,   // kind
    input  logic                   i_s_tlast,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [TDATA_OUT_W-1:0] o_m_tdata,   // normalized_score, raw_score, sequence_length
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    logic [QLEN_W-1:0]  r_query_length;
    logic [BIAS_W-1:0]  r_score_bias;
    logic [LEN_W-1:0]   r_db_pos;
    logic [LEN_W-1:0]   r_dist;
    logic               r_v1;
    t_s1_info           r_s1;
    logic [SCORE_W-1:0] r_fwd_run;
    logic [SCORE_W-1:0] r_fwd_best;
    logic [SCORE_W-1:0] r_rev_run;
    logic [SCORE_W-1:0] r_rev_best;

    logic               in_acc;
    logic               is_res;
    logic [9:0]         f_qpos;
    logic [4:0]         f_res;
    logic [7:0]         f_pval;
    logic [LEN_W-1:0]   f_diag;
    logic [LEN_W-1:0]   neg_diag;
    logic [LEN_W-1:0]   cur_dist;
    logic [QLEN_W-1:0]  qlen;
    logic               upd;
    logic [LEN_W:0]     fwd_q;
    logic [LEN_W-1:0]   rev_q;
    t_s1_info           n_s1;
    logic               mem_we;
    logic [PROF_AW-1:0] waddr;
    logic [PROF_AW-1:0] raddr_f;
    logic [PROF_AW-1:0] raddr_r;
    logic               rd_en;
    logic [7:0]         rdata_f;
    logic [7:0]         rdata_r;
    logic [7:0]         pv_f;
    logic [7:0]         pv_r;
    logic [SCORE_W-1:0] fwd_run_nx;
    logic [SCORE_W-1:0] rev_run_nx;
    logic [SCORE_W-1:0] fwd_best_nx;
    logic [SCORE_W-1:0] rev_best_nx;
    logic               s1_fire;
    logic               res_ready;
    t_seq_result        seq_res;

    // add one biased profile value, clamp to 0..255
    function automatic logic [SCORE_W-1:0] f_advance(input logic [SCORE_W-1:0] run,
                                                     input logic [7:0] pv,
                                                     input logic [BIAS_W-1:0] bias);
        logic signed [9:0] s;
        s = $signed({2'b00, run}) + $signed({{2{pv[7]}}, pv}) - $signed({3'b000, bias});
        if (s < 0) begin
            return '0;
        end else if (s > 10'sd255) begin
            return '1;
        end
        return s[SCORE_W-1:0];
    endfunction

    // item fields
    assign f_qpos = i_s_tdata[9:0];
    assign f_res  = i_s_tdata[14:10];
    assign f_pval = i_s_tdata[22:15];
    assign f_diag = i_s_tdata[38:23];
    assign is_res = (i_s_tuser == KIND_RESIDUE);
    assign in_acc = i_s_tvalid && o_s_tready;

    // intake runs while the update stage is free or moving on
    assign o_s_tready = !r_v1 || s1_fire;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_length <= '0;
            r_score_bias   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_QUERY_LENGTH: r_query_length <= i_cfg_wdata[QLEN_W-1:0];
                CFG_SCORE_BIAS:   r_score_bias   <= i_cfg_wdata[BIAS_W-1:0];
                default:          ;
            endcase
        end
    end

    // distance, query positions for both offsets, profile addresses
    always_comb begin
        qlen     = (int'(r_query_length) > MAX_QUERY_LEN) ? QLEN_W'(MAX_QUERY_LEN)
                                                          : r_query_length;
        neg_diag = LEN_W'(0) - f_diag;
        cur_dist = (r_db_pos == '0) ? ((neg_diag < f_diag) ? neg_diag : f_diag) : r_dist;
        upd      = (int'(r_db_pos) < MAX_DB_LEN);
        fwd_q    = {1'b0, r_db_pos} + {1'b0, cur_dist};
        rev_q    = r_db_pos - cur_dist;
        n_s1.fwd_en = upd && (fwd_q < (LEN_W+1)'(qlen));
        n_s1.rev_en = upd && (r_db_pos >= cur_dist) && (rev_q < LEN_W'(qlen));
        n_s1.col_ok = (int'(f_res) < PROFILE_WIDTH);
        n_s1.last   = i_s_tlast;
        n_s1.len    = upd ? (r_db_pos + LEN_W'(1)) : r_db_pos;
        raddr_f  = {QPOS_W'(fwd_q), RES_W'(f_res)};
        raddr_r  = {QPOS_W'(rev_q), RES_W'(f_res)};
        waddr    = {QPOS_W'(f_qpos), RES_W'(f_res)};
        mem_we   = in_acc && !is_res && (int'(f_qpos) < MAX_QUERY_LEN) && n_s1.col_ok;
        rd_en    = in_acc && is_res;
    end

    // sequence position and distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_db_pos <= '0;
            r_dist   <= '0;
        end else if (rd_en) begin
            if (i_s_tlast) begin
                r_db_pos <= '0;
                r_dist   <= '0;
            end else begin
                r_db_pos <= n_s1.len;
                r_dist   <= cur_dist;
            end
        end
    end

    uds_profile_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (waddr),
        .i_wdata   (f_pval),
        .i_re      (rd_en),
        .i_raddr_a (raddr_f),
        .i_raddr_b (raddr_r),
        .o_rdata_a (rdata_f),
        .o_rdata_b (rdata_r)
    );

    // update stage: running scores from the profile bytes just read
    always_comb begin
        pv_f = r_s1.col_ok ? rdata_f : 8'd0;
        pv_r = r_s1.col_ok ? rdata_r : 8'd0;
        fwd_run_nx  = r_s1.fwd_en ? f_advance(r_fwd_run, pv_f, r_score_bias) : r_fwd_run;
        rev_run_nx  = r_s1.rev_en ? f_advance(r_rev_run, pv_r, r_score_bias) : r_rev_run;
        fwd_best_nx = (fwd_run_nx > r_fwd_best) ? fwd_run_nx : r_fwd_best;
        rev_best_nx = (rev_run_nx > r_rev_best) ? rev_run_nx : r_rev_best;
        seq_res.fwd_best = fwd_best_nx;
        seq_res.rev_best = rev_best_nx;
        seq_res.len      = r_s1.len;
        s1_fire = r_v1 && (!r_s1.last || res_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_fwd_run  <= '0;
            r_fwd_best <= '0;
            r_rev_run  <= '0;
            r_rev_best <= '0;
        end else begin
            if (in_acc) begin
                r_v1 <= is_res;
            end else if (s1_fire) begin
                r_v1 <= 1'b0;
            end
            if (s1_fire) begin
                if (r_s1.last) begin
                    r_fwd_run  <= '0;
                    r_fwd_best <= '0;
                    r_rev_run  <= '0;
                    r_rev_best <= '0;
                end else begin
                    r_fwd_run  <= fwd_run_nx;
                    r_fwd_best <= fwd_best_nx;
                    r_rev_run  <= rev_run_nx;
                    r_rev_best <= rev_best_nx;
                end
            end
        end
    end

    // update stage item info
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1 <= n_s1;
        end
    end

    uds_log2_norm u_norm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (s1_fire && r_s1.last),
        .o_res_ready (res_ready),
        .i_res       (seq_res),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // a last residue leaves no sequence position behind
    a_seq_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_res && i_s_tlast) |=> (r_db_pos == '0 && r_dist == '0))
        else $error("sequence position not cleared after last residue");

    // best scores always cover the running scores
    a_best_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fwd_best >= r_fwd_run) && (r_rev_best >= r_rev_run))
        else $error("best score below running score");

    // a blocked update stage keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !s1_fire) |=> (r_v1 && $stable(r_s1)))
        else $error("update stage item changed while blocked");

    // running scores move only when an item leaves the update stage
    a_run_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |=> ($stable(r_fwd_run) && $stable(r_rev_run)))
        else $error("running score changed with no item in update stage");

endmodule
